>>> hw/rtl/nv12_to_rgb_decoder_top_defines.svh
// Assertion macros for the checker file nv2rgb_chk.sv.
`ifndef NV12_TO_RGB_DECODER_TOP_DEFINES_SVH
`define NV12_TO_RGB_DECODER_TOP_DEFINES_SVH

// Check on every clk edge outside reset.
`define NV2RGB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check on every clk edge, reset included.
`define NV2RGB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/nv2rgb_pkg.sv
`default_nettype none

package nv2rgb_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(1920);
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(1080);

	// BT.601 coefficients scaled by COEF_SCALE
	localparam longint COEF_SCALE = 100000;
	localparam longint C_RV       = 113983;
	localparam longint C_GU       = 39465;
	localparam longint C_GV       = 58060;
	localparam longint C_BU       = 203211;

	localparam logic [8:0] CHROMA_OFFSET = 9'd128;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
	} yuv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       row_end;
		logic       frame_end;
	} rgb_t;

	// Pixel after chroma lookup, handed to the color math
	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
		logic       row_end;
		logic       frame_end;
	} pix_s1_t;

endpackage

`default_nettype wire

>>> hw/rtl/nv2rgb_line.sv
`default_nettype none

module nv2rgb_line #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [nv2rgb_pkg::CFG_W-1:0] frame_width,
	input  wire logic [nv2rgb_pkg::CFG_W-1:0] frame_height,
	input  wire logic                         yuv_valid,
	output logic                              yuv_stall,
	input  wire nv2rgb_pkg::yuv_t             yuv,
	input  wire logic                         s2_free,
	output logic                              s1_valid,
	output nv2rgb_pkg::pix_s1_t               s1
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW    = (LINE_DEPTH > 2) ? $clog2(LINE_DEPTH) : 1;
	localparam int EW_W  = ($clog2(MAX_WIDTH + 1) > nv2rgb_pkg::CFG_W) ?
		$clog2(MAX_WIDTH + 1) : nv2rgb_pkg::CFG_W;
	localparam int EW_H  = ($clog2(MAX_HEIGHT + 1) > nv2rgb_pkg::CFG_W) ?
		$clog2(MAX_HEIGHT + 1) : nv2rgb_pkg::CFG_W;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [15:0]      held_q;
	logic [15:0]      rd_q;
	logic [15:0]      line_mem [LINE_DEPTH];

	logic             s1_valid_q;
	logic [7:0]       luma_s1;
	logic [15:0]      uv_s1;
	logic             odd_row_s1;
	logic             row_end_s1;
	logic             frame_end_s1;

	logic [EW_W-1:0]  w_ext, w_eff;
	logic [EW_H-1:0]  h_ext, h_eff;
	logic [COL_W-1:0] w_last;
	logic [ROW_W-1:0] h_last;
	logic             accept, row_end, frame_end, wr_en;
	logic [AW-1:0]    idx;
	logic [15:0]      uv_in;

	// Clamp the programmed frame size to what the line buffer supports
	always_comb begin
		w_ext = EW_W'(frame_width);
		if (w_ext < EW_W'(2)) begin
			w_eff = EW_W'(2);
		end else if (w_ext > EW_W'(MAX_WIDTH)) begin
			w_eff = EW_W'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		w_eff[0] = 1'b0;
		w_last = COL_W'(w_eff - EW_W'(1));

		h_ext = EW_H'(frame_height);
		if (h_ext < EW_H'(1)) begin
			h_eff = EW_H'(1);
		end else if (h_ext > EW_H'(MAX_HEIGHT)) begin
			h_eff = EW_H'(MAX_HEIGHT);
		end else begin
			h_eff = h_ext;
		end
		h_last = ROW_W'(h_eff - EW_H'(1));
	end

	assign yuv_stall = s1_valid_q && !s2_free;
	assign accept    = yuv_valid && !yuv_stall;
	assign row_end   = col_q >= w_last;
	assign frame_end = row_end && (row_q >= h_last);
	assign idx       = AW'(col_q >> 1);
	assign uv_in     = {yuv.chroma_u, yuv.chroma_v};
	// Even row, even column: the beat carries fresh chroma for its 2x2 block
	assign wr_en     = accept && !row_q[0] && !col_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (wr_en) begin
				held_q <= uv_in;
			end
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Even rows fill the line, odd rows read it back one row later
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[idx] <= uv_in;
		end
		if (accept && row_q[0]) begin
			rd_q <= line_mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s2_free) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1      <= yuv.luma;
			uv_s1        <= wr_en ? uv_in : held_q;
			odd_row_s1   <= row_q[0];
			row_end_s1   <= row_end;
			frame_end_s1 <= frame_end;
		end
	end

	always_comb begin
		s1.luma      = luma_s1;
		s1.chroma_u  = odd_row_s1 ? rd_q[15:8] : uv_s1[15:8];
		s1.chroma_v  = odd_row_s1 ? rd_q[7:0] : uv_s1[7:0];
		s1.row_end   = row_end_s1;
		s1.frame_end = frame_end_s1;
	end

	assign s1_valid = s1_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/nv2rgb_csc.sv
`default_nettype none

module nv2rgb_csc #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s1_valid,
	input  wire nv2rgb_pkg::pix_s1_t s1,
	output logic                     s2_free,
	output logic                     rgb_valid,
	input  wire logic                rgb_stall,
	output nv2rgb_pkg::rgb_t         rgb
);

	localparam int KW    = COEF_FRAC_BITS + 3;
	localparam int PW    = KW + 9;
	localparam int ACC_W = PW + 1;

	localparam longint ONE_Q = longint'(1) << COEF_FRAC_BITS;
	localparam longint HALF  = nv2rgb_pkg::COEF_SCALE / 2;

	localparam logic signed [KW-1:0] K_RV =
		KW'((nv2rgb_pkg::C_RV * ONE_Q + HALF) / nv2rgb_pkg::COEF_SCALE);
	localparam logic signed [KW-1:0] K_GU =
		KW'((nv2rgb_pkg::C_GU * ONE_Q + HALF) / nv2rgb_pkg::COEF_SCALE);
	localparam logic signed [KW-1:0] K_GV =
		KW'((nv2rgb_pkg::C_GV * ONE_Q + HALF) / nv2rgb_pkg::COEF_SCALE);
	localparam logic signed [KW-1:0] K_BU =
		KW'((nv2rgb_pkg::C_BU * ONE_Q + HALF) / nv2rgb_pkg::COEF_SCALE);

	// Truncate toward zero, then clip to a byte
	function automatic logic [7:0] to_byte(input logic signed [ACC_W-1:0] acc);
		logic [7:0] res;
		if (acc[ACC_W-1]) begin
			res = 8'h00;
		end else if (|acc[ACC_W-2:COEF_FRAC_BITS+8]) begin
			res = 8'hFF;
		end else begin
			res = acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
		end
		return res;
	endfunction

	logic signed [8:0]    u_c, v_c;
	logic                 take_s1, ready_out;

	logic                 v2_q;
	logic [7:0]           luma_s2;
	logic signed [PW-1:0] prod_rv_s2, prod_gu_s2, prod_gv_s2, prod_bu_s2;
	logic                 row_end_s2, frame_end_s2;

	logic signed [ACC_W-1:0] base, acc_r, acc_g, acc_b;

	logic                 rgb_valid_q;
	nv2rgb_pkg::rgb_t     rgb_q;

	assign ready_out = !rgb_valid_q || !rgb_stall;
	assign s2_free   = !v2_q || ready_out;
	assign take_s1   = s1_valid && s2_free;

	assign u_c = signed'(9'(s1.chroma_u) - nv2rgb_pkg::CHROMA_OFFSET);
	assign v_c = signed'(9'(s1.chroma_v) - nv2rgb_pkg::CHROMA_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (s2_free) begin
			v2_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			luma_s2      <= s1.luma;
			prod_rv_s2   <= PW'(K_RV) * PW'(v_c);
			prod_gu_s2   <= PW'(K_GU) * PW'(u_c);
			prod_gv_s2   <= PW'(K_GV) * PW'(v_c);
			prod_bu_s2   <= PW'(K_BU) * PW'(u_c);
			row_end_s2   <= s1.row_end;
			frame_end_s2 <= s1.frame_end;
		end
	end

	always_comb begin
		base  = signed'(ACC_W'(luma_s2) << COEF_FRAC_BITS);
		acc_r = base + ACC_W'(prod_rv_s2);
		acc_g = base - ACC_W'(prod_gu_s2) - ACC_W'(prod_gv_s2);
		acc_b = base + ACC_W'(prod_bu_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_valid_q <= 1'b0;
		end else if (ready_out) begin
			rgb_valid_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (v2_q && ready_out) begin
			rgb_q.red       <= to_byte(acc_r);
			rgb_q.green     <= to_byte(acc_g);
			rgb_q.blue      <= to_byte(acc_b);
			rgb_q.row_end   <= row_end_s2;
			rgb_q.frame_end <= frame_end_s2;
		end
	end

	assign rgb_valid = rgb_valid_q;
	assign rgb       = rgb_q;

endmodule

`default_nettype wire

>>> hw/rtl/nv12_to_rgb_decoder_top.sv
// NV12 to RGB converter, BT.601 coefficients.
// yuv channel: one pixel per beat in raster order. On even rows at even
//   columns the beat also carries U and V of its 2x2 block; elsewhere they
//   are ignored. Odd rows take chroma from the line buffer written by the
//   row above.
// rgb channel: one RGB pixel per yuv beat, with row_end on the last pixel
//   of a row and frame_end on the last pixel of the frame.
// cfg channel: frame_width (index 0) and frame_height (index 1); cfg_ready
//   is always high. Write only while no pixel is in flight.
// Pipeline: a yuv beat is registered after the line buffer read, after the
//   products and after the sum and clip, which drives rgb_valid. Throughput:
//   one pixel per clock while rgb_stall does not back up the pipeline, set by
//   the single-port line buffer doing one read or one write per pixel.
// When the rgb side stalls, the pipeline keeps taking pixels until its three
//   stages are full, then raises yuv_stall.
// Reset clears the row/column counters, held chroma and all stage valids and
//   loads width 1920, height 1080. The line buffer is not cleared: odd rows
//   read only entries written by the even row above.
`default_nettype none

module nv12_to_rgb_decoder_top #(
	parameter int MAX_WIDTH      = 4096,
	parameter int MAX_HEIGHT     = 4096,
	parameter int COEF_FRAC_BITS = 12
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             yuv_valid,
	output logic                                  yuv_stall,
	input  wire nv2rgb_pkg::yuv_t                 yuv,
	output logic                                  rgb_valid,
	input  wire logic                             rgb_stall,
	output nv2rgb_pkg::rgb_t                      rgb,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [nv2rgb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nv2rgb_pkg::CFG_W-1:0]     cfg_data
);

	logic [nv2rgb_pkg::CFG_W-1:0] frame_width_q;
	logic [nv2rgb_pkg::CFG_W-1:0] frame_height_q;
	logic                         s1_valid;
	nv2rgb_pkg::pix_s1_t          s1;
	logic                         s2_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= nv2rgb_pkg::FRAME_WIDTH_RST;
			frame_height_q <= nv2rgb_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nv2rgb_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				nv2rgb_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	nv2rgb_line #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_line (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.yuv_valid    (yuv_valid),
		.yuv_stall    (yuv_stall),
		.yuv          (yuv),
		.s2_free      (s2_free),
		.s1_valid     (s1_valid),
		.s1           (s1)
	);

	nv2rgb_csc #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_csc (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1        (s1),
		.s2_free   (s2_free),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb       (rgb)
	);

endmodule

`default_nettype wire

>>> hw/rtl/nv2rgb_chk.sv
`default_nettype none

`include "nv12_to_rgb_decoder_top_defines.svh"

module nv2rgb_chk (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             yuv_stall,
	input wire logic             rgb_valid,
	input wire logic             rgb_stall,
	input wire nv2rgb_pkg::rgb_t rgb
);

	// A stalled rgb beat stays put
	`NV2RGB_ASSERT(a_rgb_hold, rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb), "rgb beat changed while stalled")

	// Input backpressure only comes from a stalled, full output
	`NV2RGB_ASSERT(a_stall_cause, yuv_stall |-> rgb_valid && rgb_stall, "yuv_stall without rgb backpressure")

	`NV2RGB_ASSERT(a_frame_row, rgb_valid && rgb.frame_end |-> rgb.row_end, "frame_end without row_end")

	`NV2RGB_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !rgb_valid, "rgb_valid during reset")

endmodule

bind nv12_to_rgb_decoder_top nv2rgb_chk u_nv2rgb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.yuv_stall (yuv_stall),
	.rgb_valid (rgb_valid),
	.rgb_stall (rgb_stall),
	.rgb       (rgb)
);

`default_nettype wire
